### design/dlm_pkg.sv
`default_nettype none

package dlm_pkg;

    localparam int DLM_WIDTH    = 16;
    localparam int DLM_CHANNELS = 16;

    // word select codes
    localparam logic [3:0] WS_EXT_INV    = 4'd0;
    localparam logic [3:0] WS_EXT_STATE  = 4'd1;
    localparam logic [3:0] WS_EXT_RISE   = 4'd2;
    localparam logic [3:0] WS_EXT_FALL   = 4'd3;
    localparam logic [3:0] WS_FB_INV     = 4'd4;
    localparam logic [3:0] WS_FB_STATE   = 4'd5;
    localparam logic [3:0] WS_FB_RISE    = 4'd6;
    localparam logic [3:0] WS_FB_FALL    = 4'd7;
    localparam logic [3:0] WS_USAGE      = 4'd8;
    localparam logic [3:0] WS_OPERATION  = 4'd9;

    // mask slot within a group of four
    localparam logic [1:0] MASK_INV   = 2'd0;
    localparam logic [1:0] MASK_STATE = 2'd1;
    localparam logic [1:0] MASK_RISE  = 2'd2;
    localparam logic [1:0] MASK_FALL  = 2'd3;

    // item opcodes
    localparam logic OP_EVAL  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // reduce operations
    localparam logic [2:0] RED_AND    = 3'd0;
    localparam logic [2:0] RED_NAND   = 3'd1;
    localparam logic [2:0] RED_OR     = 3'd2;
    localparam logic [2:0] RED_NOR    = 3'd3;
    localparam logic [2:0] RED_XOR    = 3'd4;
    localparam logic [2:0] RED_XNOR   = 3'd5;
    localparam logic [2:0] RED_PARITY = 3'd6;

    typedef logic [3:0][DLM_WIDTH-1:0] dlm_masks_t;

    typedef struct packed {
        dlm_masks_t                 ext;
        dlm_masks_t                 fb;
        logic [2*DLM_WIDTH-1:0]     usage;
        logic [2:0]                 oper;
    } dlm_cfg_t;

    typedef struct packed {
        logic                       en;
        logic [3:0]                 chan;
        logic [3:0]                 word;
        logic [2*DLM_WIDTH-1:0]     value;
    } dlm_wr_t;

endpackage

`default_nettype wire

### design/dlm_table.sv
`default_nettype none

module dlm_table (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire dlm_pkg::dlm_wr_t wr,
    output dlm_pkg::dlm_cfg_t     cfg [dlm_pkg::DLM_CHANNELS]
);

    dlm_pkg::dlm_cfg_t cfg_reg [dlm_pkg::DLM_CHANNELS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < dlm_pkg::DLM_CHANNELS; c++) begin
                // fall, rise, state, invert
                cfg_reg[c].ext <= {{(2*dlm_pkg::DLM_WIDTH){1'b0}},
                                   (dlm_pkg::DLM_WIDTH)'(1) << c,
                                   {dlm_pkg::DLM_WIDTH{1'b0}}};
                cfg_reg[c].fb <= '0;
                cfg_reg[c].usage <= (2*dlm_pkg::DLM_WIDTH)'(1) << c;
                cfg_reg[c].oper <= dlm_pkg::RED_AND;
            end
        end else if (wr.en) begin
            for (int c = 0; c < dlm_pkg::DLM_CHANNELS; c++) begin
                if (wr.chan == 4'(c)) begin
                    unique case (wr.word) inside
                        dlm_pkg::WS_EXT_INV, dlm_pkg::WS_EXT_STATE,
                        dlm_pkg::WS_EXT_RISE, dlm_pkg::WS_EXT_FALL: begin
                            cfg_reg[c].ext[wr.word[1:0]] <=
                                wr.value[dlm_pkg::DLM_WIDTH-1:0];
                        end
                        dlm_pkg::WS_FB_INV, dlm_pkg::WS_FB_STATE,
                        dlm_pkg::WS_FB_RISE, dlm_pkg::WS_FB_FALL: begin
                            cfg_reg[c].fb[wr.word[1:0]] <=
                                wr.value[dlm_pkg::DLM_WIDTH-1:0];
                        end
                        dlm_pkg::WS_USAGE: begin
                            cfg_reg[c].usage <= wr.value;
                        end
                        dlm_pkg::WS_OPERATION: begin
                            cfg_reg[c].oper <= wr.value[2:0];
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### design/dlm_channel.sv
`default_nettype none

module dlm_channel (
    input  wire dlm_pkg::dlm_cfg_t              cfg,
    input  wire logic [dlm_pkg::DLM_WIDTH-1:0] ext_levels,
    input  wire logic [dlm_pkg::DLM_WIDTH-1:0] ext_rises,
    input  wire logic [dlm_pkg::DLM_WIDTH-1:0] ext_falls,
    input  wire logic [dlm_pkg::DLM_WIDTH-1:0] fb_levels,
    input  wire logic [dlm_pkg::DLM_WIDTH-1:0] fb_rises,
    input  wire logic [dlm_pkg::DLM_WIDTH-1:0] fb_falls,
    output logic                                result
);

    function automatic logic [dlm_pkg::DLM_WIDTH-1:0] masked_half(
        input dlm_pkg::dlm_masks_t           m,
        input logic [dlm_pkg::DLM_WIDTH-1:0] lv,
        input logic [dlm_pkg::DLM_WIDTH-1:0] ri,
        input logic [dlm_pkg::DLM_WIDTH-1:0] fa
    );
        return ((lv ^ m[dlm_pkg::MASK_INV]) & m[dlm_pkg::MASK_STATE])
             | (ri & m[dlm_pkg::MASK_RISE])
             | (fa & m[dlm_pkg::MASK_FALL]);
    endfunction

    logic [2*dlm_pkg::DLM_WIDTH-1:0] used;
    logic                            all_set;
    logic                            any_set;
    logic                            odd;

    assign used    = {masked_half(cfg.fb, fb_levels, fb_rises, fb_falls),
                      masked_half(cfg.ext, ext_levels, ext_rises, ext_falls)} & cfg.usage;
    assign all_set = (used == cfg.usage);
    assign any_set = |used;
    assign odd     = ^used;

    always_comb begin
        case (cfg.oper) inside
            dlm_pkg::RED_AND:                      result = all_set;
            dlm_pkg::RED_NAND:                     result = !all_set;
            dlm_pkg::RED_OR:                       result = any_set;
            dlm_pkg::RED_NOR:                      result = !any_set;
            dlm_pkg::RED_XOR, dlm_pkg::RED_PARITY: result = odd;
            dlm_pkg::RED_XNOR:                     result = !odd;
            default:                               result = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

### design/digital_logic_mixer.sv
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  op, ext_levels/rises/falls, channel_sel,
//                                         word_sel, word_value
// m_        out        m_valid / m_ready  out_levels, out_rises, out_falls, out_changes
//
// Items register on entry and are worked one per cycle unless a stalled result
// holds an evaluate item; each result is registered. Feedback from the previous
// outputs is a single loop through the output register and mask-and-reduce logic.
// Table writes take effect before the next item is worked and give no result.
// Reset restores the default tables and clears the outputs. A stalled result
// holds s_ready low only while an evaluate item waits in the entry register.
`default_nettype none

module digital_logic_mixer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_op,
    input  wire logic [15:0] s_ext_levels,
    input  wire logic [15:0] s_ext_rises,
    input  wire logic [15:0] s_ext_falls,
    input  wire logic [3:0]  s_channel_sel,
    input  wire logic [3:0]  s_word_sel,
    input  wire logic [31:0] s_word_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_out_levels,
    output logic [15:0]      m_out_rises,
    output logic [15:0]      m_out_falls,
    output logic [15:0]      m_out_changes
);

    localparam int W = dlm_pkg::DLM_WIDTH;

    logic         in_valid_reg;
    logic         op_reg;
    logic [W-1:0] lv_reg;
    logic [W-1:0] ri_reg;
    logic [W-1:0] fa_reg;
    logic [3:0]   chan_reg;
    logic [3:0]   word_reg;
    logic [31:0]  value_reg;

    logic         m_valid_reg;
    logic         m_valid_next;
    logic [W-1:0] levels_reg;
    logic [W-1:0] rises_reg;
    logic [W-1:0] falls_reg;
    logic [W-1:0] changes_reg;
    logic [W-1:0] levels_next;

    logic advance;
    logic eval_go;

    dlm_pkg::dlm_wr_t  wr;
    dlm_pkg::dlm_cfg_t cfg [dlm_pkg::DLM_CHANNELS];

    assign advance = in_valid_reg
                   && (op_reg == dlm_pkg::OP_WRITE || !m_valid_reg || m_ready);
    assign eval_go = advance && op_reg == dlm_pkg::OP_EVAL;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg    <= s_op;
            lv_reg    <= s_ext_levels;
            ri_reg    <= s_ext_rises;
            fa_reg    <= s_ext_falls;
            chan_reg  <= s_channel_sel;
            word_reg  <= s_word_sel;
            value_reg <= s_word_value;
        end
    end

    assign wr.en    = advance && op_reg == dlm_pkg::OP_WRITE;
    assign wr.chan  = chan_reg;
    assign wr.word  = word_reg;
    assign wr.value = value_reg;

    dlm_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .cfg     (cfg)
    );

    for (genvar c = 0; c < dlm_pkg::DLM_CHANNELS; c++) begin : g_chan
        dlm_channel u_chan (
            .cfg        (cfg[c]),
            .ext_levels (lv_reg),
            .ext_rises  (ri_reg),
            .ext_falls  (fa_reg),
            .fb_levels  (levels_reg),
            .fb_rises   (rises_reg),
            .fb_falls   (falls_reg),
            .result     (levels_next[c])
        );
    end

    for (genvar c = dlm_pkg::DLM_CHANNELS; c < W; c++) begin : g_unused
        assign levels_next[c] = 1'b0;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (eval_go) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // output register doubles as the feedback state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            levels_reg  <= '0;
            rises_reg   <= '0;
            falls_reg   <= '0;
            changes_reg <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (eval_go) begin
                levels_reg  <= levels_next;
                rises_reg   <= ~levels_reg & levels_next;
                falls_reg   <= levels_reg & ~levels_next;
                changes_reg <= levels_reg ^ levels_next;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_levels  = levels_reg;
    assign m_out_rises   = rises_reg;
    assign m_out_falls   = falls_reg;
    assign m_out_changes = changes_reg;

endmodule

`default_nettype wire

### design/dlm_checker.sv
`default_nettype none

module dlm_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [15:0] m_out_levels,
    input wire logic [15:0] m_out_rises,
    input wire logic [15:0] m_out_falls,
    input wire logic [15:0] m_out_changes
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_levels)
            && $stable(m_out_rises) && $stable(m_out_falls) && $stable(m_out_changes))
        else $error("stalled result changed");

    a_edge_split: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_out_changes == (m_out_rises | m_out_falls)
            && (m_out_rises & m_out_falls) == 16'h0000)
        else $error("edge flags inconsistent");

    a_edge_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_out_rises & ~m_out_levels) == 16'h0000
            && (m_out_falls & m_out_levels) == 16'h0000)
        else $error("edge flags disagree with levels");

endmodule

bind digital_logic_mixer dlm_checker u_dlm_checker (.*);

`default_nettype wire
